// ===== sv/spmd_pkg.sv =====
`default_nettype none
package spmd_pkg;
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
endpackage
`default_nettype wire

// ===== sv/shortest_path_matrix_dijkstra_core.sv =====
`default_nettype none
// Channel   | Ports                                            | Handshake
// request   | req_action .. req_end_node                       | start & !busy
// response  | rsp_found rsp_path_node rsp_path_length rsp_last | rsp_valid, one cycle
// config    | csr_wdata (node_count)                           | csr_valid & csr_ready
//
// A load beat is registered before it is written, and busy holds off the next beat.
// A query searches in rounds: each round scans the distance memory for the minimum,
// then walks one matrix row through the weight memory's single read port. The path
// is then traced back node by node and played out one beat per cycle from the path
// buffer. Reset is synchronous and clears control state only. The receiver cannot
// stall, so results simply stream.
module shortest_path_matrix_dijkstra_core
   import spmd_pkg::*;
#(
   parameter int NODE_CAPACITY = 32,
   parameter int WEIGHT_BITS   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_action,
   input  wire logic [4:0]  req_row_node,
   input  wire logic [4:0]  req_col_node,
   input  wire logic signed [15:0] req_edge_weight,
   input  wire logic [4:0]  req_start_node,
   input  wire logic [4:0]  req_end_node,
   output logic             rsp_valid,
   output logic             rsp_found,
   output logic [4:0]       rsp_path_node,
   output logic [5:0]       rsp_path_length,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [5:0]  csr_wdata
);
   localparam int AW = $clog2(NODE_CAPACITY);
   localparam int DW = WEIGHT_BITS + 6;
   localparam int NMAX = (NODE_CAPACITY < 32) ? NODE_CAPACITY : 32;
   localparam logic [WEIGHT_BITS-1:0] WMAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};

   localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_SCAN = 4'd2,
      S_PICK = 4'd3, S_RELAX = 4'd4, S_TRACE = 4'd5, S_TRACEW = 4'd6,
      S_EMIT = 4'd7, S_EMITW = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [5:0] ncfg_ff;
   logic [5:0] n_act;
   logic [AW-1:0] s_ff, e_ff, u_ff;
   logic [6:0] cnt_ff;     // sweep position; runs up to N+1
   logic [5:0] round_ff;
   logic pick_ff;
   logic [AW-1:0] best_ff;
   logic [DW-1:0] bestd_ff, du_ff;
   logic [NODE_CAPACITY-1:0] reached_ff, visited_ff, haspred_ff;
   logic [5:0] plen_ff;
   logic [AW-1:0] cur_ff;

   always_comb begin
      n_act = (ncfg_ff == 6'd0) ? 6'd1 : ncfg_ff;
      if (n_act > 6'(NMAX)) n_act = 6'(NMAX);
   end

   // Weight memory: bit WEIGHT_BITS is the edge-present flag.
   logic w_we;
   logic [2*AW-1:0] w_wa, w_ra;
   logic [WEIGHT_BITS:0] w_wd, w_rd;
   logic [WEIGHT_BITS-1:0] w_sat;
   always_comb begin
      w_sat = (req_edge_weight > $signed({1'b0, WMAX})) ?
         WMAX : WEIGHT_BITS'(req_edge_weight[14:0]);
      w_wd = req_edge_weight[15] ? '0 : {1'b1, w_sat};
   end
   // Distance and predecessor memories, and the path buffer.
   logic d_we; logic [AW-1:0] d_wa, d_ra; logic [DW-1:0] d_wd, d_rd;
   logic p_we; logic [AW-1:0] p_wa, p_ra; logic [AW-1:0] p_wd, p_rd;
   logic b_we; logic [AW-1:0] b_wa, b_ra; logic [4:0] b_wd, b_rd;

   // Write the load in the cycle after acceptance so busy blocks the next beat.
   logic ld_ff; logic [2*AW-1:0] ldaddr_ff; logic [WEIGHT_BITS:0] lddata_ff;

   spmd_ram #(.WIDTH(WEIGHT_BITS+1), .DEPTH(NODE_CAPACITY*NODE_CAPACITY)) u_wmem (
      .clock, .wr_en(w_we), .wr_addr(w_wa), .wr_data(lddata_ff), .rd_addr(w_ra),
      .rd_data(w_rd));
   spmd_ram #(.WIDTH(DW), .DEPTH(NODE_CAPACITY)) u_dmem (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd), .rd_addr(d_ra), .rd_data(d_rd));
   spmd_ram #(.WIDTH(AW), .DEPTH(NODE_CAPACITY)) u_pmem (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd));
   spmd_ram #(.WIDTH(5), .DEPTH(NODE_CAPACITY)) u_bmem (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd), .rd_addr(b_ra), .rd_data(b_rd));

   logic accept;
   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE) || w_we;
   assign csr_ready = (state_ff == S_IDLE);

   // The lagged sweep index: data read at cnt-1 arrives now.
   logic [AW-1:0] lag;
   logic lag_ok;
   logic [DW-1:0] alt;
   assign lag = AW'(cnt_ff - 7'd1);
   assign lag_ok = (cnt_ff != 7'd0) && (cnt_ff <= 7'(n_act));
   assign alt = du_ff + DW'(w_rd[WEIGHT_BITS-1:0]);

   assign w_we = ld_ff;
   assign w_wa = ldaddr_ff;

   always_comb begin
      w_ra = {u_ff, AW'(cnt_ff)};
      d_ra = AW'(cnt_ff);
      d_we = 1'b0; d_wa = lag; d_wd = alt;
      p_we = 1'b0; p_wa = lag; p_wd = u_ff;
      p_ra = cur_ff;
      b_we = 1'b0; b_wa = AW'(plen_ff); b_wd = 5'(cur_ff);
      // The entry at cnt-1 is read so that it shows when cnt has counted down to it.
      b_ra = AW'(cnt_ff - 7'd1);
      if (state_ff == S_INIT) begin
         d_we = 1'b1; d_wa = s_ff; d_wd = '0;
      end
      if (state_ff == S_RELAX && lag_ok && w_rd[WEIGHT_BITS] &&
          !visited_ff[lag] && (!reached_ff[lag] || alt < d_rd)) begin
         d_we = 1'b1; p_we = 1'b1;
      end
      if (state_ff == S_TRACEW) b_we = 1'b1;
      if (state_ff == S_RELAX) d_ra = AW'(cnt_ff);
   end

   logic upd;
   assign upd = d_we && state_ff == S_RELAX;

   // A result beat goes out for an immediate query answer, for an unreachable end
   // after the search, and for every path entry once its buffer read has landed.
   logic rsp_fire;
   assign rsp_fire =
      (accept && req_action == ACT_QUERY && (req_start_node == req_end_node ||
         6'(req_start_node) >= n_act || 6'(req_end_node) >= n_act)) ||
      (state_ff == S_TRACE && !reached_ff[e_ff]) ||
      (state_ff == S_EMIT && cnt_ff != 7'(plen_ff));

   always_ff @(posedge clock) begin
      ld_ff <= !reset && accept && (req_action == ACT_LOAD) &&
         (32'(req_row_node) < NODE_CAPACITY) && (32'(req_col_node) < NODE_CAPACITY);
      rsp_valid <= !reset && rsp_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ncfg_ff <= 6'd32;
      end else begin
         if (csr_valid && csr_ready) ncfg_ff <= csr_wdata;
         unique case (state_ff)
            S_IDLE: if (accept) begin
               if (req_action == ACT_LOAD) begin
                  ldaddr_ff <= {AW'(req_row_node), AW'(req_col_node)};
                  lddata_ff <= w_wd;
               end else if (req_start_node == req_end_node) begin
                  rsp_found <= 1'b1;
                  rsp_path_node <= req_start_node; rsp_path_length <= 6'd1;
                  rsp_last <= 1'b1;
               end else if (6'(req_start_node) >= n_act || 6'(req_end_node) >= n_act) begin
                  rsp_found <= 1'b0; rsp_path_node <= '0;
                  rsp_path_length <= '0; rsp_last <= 1'b1;
               end else begin
                  s_ff <= AW'(req_start_node); e_ff <= AW'(req_end_node);
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               reached_ff <= NODE_CAPACITY'(1) << s_ff;
               visited_ff <= '0; haspred_ff <= '0;
               round_ff <= '0; cnt_ff <= '0; pick_ff <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (lag_ok && reached_ff[lag] && !visited_ff[lag] &&
                   (!pick_ff || d_rd < bestd_ff)) begin
                  pick_ff <= 1'b1; best_ff <= lag; bestd_ff <= d_rd;
               end
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(n_act)) state_ff <= S_PICK;
            end
            S_PICK: begin
               if (!pick_ff) begin
                  state_ff <= S_TRACE;
               end else begin
                  visited_ff[best_ff] <= 1'b1;
                  u_ff <= best_ff; du_ff <= bestd_ff;
                  cnt_ff <= '0; state_ff <= S_RELAX;
               end
            end
            S_RELAX: begin
               if (upd) begin
                  reached_ff[lag] <= 1'b1; haspred_ff[lag] <= 1'b1;
               end
               if (cnt_ff == 7'(n_act)) begin
                  round_ff <= round_ff + 6'd1; cnt_ff <= '0; pick_ff <= 1'b0;
                  state_ff <= (round_ff + 6'd1 == n_act) ? S_TRACE : S_SCAN;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            S_TRACE: begin
               if (!reached_ff[e_ff]) begin
                  rsp_found <= 1'b0; rsp_path_node <= '0;
                  rsp_path_length <= '0; rsp_last <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  cur_ff <= e_ff; plen_ff <= '0; state_ff <= S_TRACEW;
               end
            end
            S_TRACEW: begin
               // Buffer gets cur; predecessor of cur is read this cycle.
               plen_ff <= plen_ff + 6'd1;
               if (!haspred_ff[cur_ff] || plen_ff + 6'd1 >= n_act) begin
                  // Start at the path length, one above the last buffer entry, so the first read can land.
                  cnt_ff <= 7'(plen_ff) + 7'd1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_EMITW;
               end
            end
            S_EMITW: begin
               // Predecessor data is now valid.
               cur_ff <= p_rd; state_ff <= S_TRACEW;
            end
            S_EMIT: begin
               // The buffer entry at cnt was read last cycle and is on b_rd now.
               if (cnt_ff != 7'(plen_ff)) begin
                  rsp_found <= 1'b1; rsp_path_node <= b_rd;
                  rsp_path_length <= plen_ff; rsp_last <= (cnt_ff == 7'd0);
               end
               if (cnt_ff == 7'd0) begin
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 7'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   property p_one_beat;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_last |=> !rsp_valid || state_ff == S_IDLE;
   endproperty
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> state_ff == S_IDLE) else $error("last beat while still active");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == S_IDLE) else $error("accept outside idle");
   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_path_length != 6'd0) else $error("empty found path");
   a_pick: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RELAX |-> visited_ff[u_ff]) else $error("relaxing unvisited node");
   a_seq: assert property (p_one_beat) else $error("beat after last");
endmodule
`default_nettype wire

// ===== sv/spmd_ram.sv =====
`default_nettype none
module spmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb
   import spmd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // One result beat of a route query.
   typedef struct packed {
      logic       found;
      logic [4:0] node;
      logic [5:0] len;
      logic       tail;
   } hop_type;

   // One request beat: either a matrix load or a route query.
   typedef struct {
      logic              act;
      logic [4:0]        row;
      logic [4:0]        col;
      logic signed [15:0] wt;
      logic [4:0]        src;
      logic [4:0]        dst;
      bit                typed;
      hop_type           hop;
   } beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_action = ACT_LOAD;
   logic [4:0]        req_row_node = '0;
   logic [4:0]        req_col_node = '0;
   logic signed [15:0] req_edge_weight = '0;
   logic [4:0]        req_start_node = '0;
   logic [4:0]        req_end_node = '0;
   logic              rsp_valid;
   logic              rsp_found;
   logic [4:0]        rsp_path_node;
   logic [5:0]        rsp_path_length;
   logic              rsp_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [5:0]        csr_wdata = '0;

   shortest_path_matrix_dijkstra_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_row_node(req_row_node),
      .req_col_node(req_col_node), .req_edge_weight(req_edge_weight),
      .req_start_node(req_start_node), .req_end_node(req_end_node),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found), .rsp_path_node(rsp_path_node),
      .rsp_path_length(rsp_path_length), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the block: the weight matrix with its edge bits, and the
   // active node count derived from the last register write.
   logic [15:0] shadow_wt[1024];
   bit          shadow_edge[1024];
   int          active_nodes = 32;

   hop_type     route_q[$];
   int          errors = 0;
   int          queries = 0;
   int          loads = 0;
   int          hops_seen = 0;
   int          idle_pct = 0;
   longint      cycles = 0;

   // Timeout guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("%0t timeout with %0d results outstanding", $time, route_q.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   // Result checker. Outputs are sampled at the edge that accepts them, so the
   // values read here are the ones held during the strobe cycle.
   always @(posedge clock) begin
      hop_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_found, rsp_path_node, rsp_path_length, rsp_last};
         hops_seen++;
         if (route_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result beat: expected none, actual %p", $time, got);
         end else begin
            want = route_q.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t result mismatch: expected %p, actual %p", $time, want, got);
            end
         end
      end
   end

   // Map the raw register value onto the node count the block really uses.
   function automatic int clamp_nodes(logic [5:0] v);
      if (v == 0) return 1;
      if (v > 32) return 32;
      return v;
   endfunction

   // Array-scan Dijkstra over the shadow matrix. Pushes every hop the block
   // should emit for a query from src to dst.
   function automatic void chart_route(int src, int dst);
      longint cost[32];
      bit     seen[32];
      bit     done[32];
      bit     linked[32];
      int     pred[32];
      int     trail[32];
      int     n, u, cnt, cur;
      bit     pick;
      longint alt;
      n = active_nodes;
      if (src == dst) begin
         route_q.push_back('{1'b1, 5'(src), 6'd1, 1'b1});
         return;
      end
      if (src >= n || dst >= n) begin
         route_q.push_back('{1'b0, 5'd0, 6'd0, 1'b1});
         return;
      end
      for (int i = 0; i < 32; i++) begin
         cost[i] = 0; seen[i] = 0; done[i] = 0; linked[i] = 0; pred[i] = 0;
      end
      seen[src] = 1;
      for (int r = 0; r < n; r++) begin
         pick = 0;
         u = 0;
         for (int j = 0; j < n; j++) begin
            if (done[j] || !seen[j]) continue;
            if (!pick || cost[j] < cost[u]) begin
               u = j;
               pick = 1;
            end
         end
         if (!pick) break;
         done[u] = 1;
         for (int v = 0; v < n; v++) begin
            if (!shadow_edge[u*32+v]) continue;
            alt = cost[u] + shadow_wt[u*32+v];
            if (!seen[v] || alt < cost[v]) begin
               cost[v] = alt;
               seen[v] = 1;
               pred[v] = u;
               linked[v] = 1;
            end
         end
      end
      if (!seen[dst]) begin
         route_q.push_back('{1'b0, 5'd0, 6'd0, 1'b1});
         return;
      end
      cnt = 0;
      cur = dst;
      forever begin
         trail[cnt] = cur;
         cnt++;
         if (!linked[cur] || cnt >= n) break;
         cur = pred[cur] % 32;
      end
      for (int j = 0; j < cnt; j++)
         route_q.push_back('{1'b1, 5'(trail[cnt-1-j]), 6'(cnt), j + 1 == cnt});
   endfunction

   // Drive one request beat and hold it until the block takes it. Returns at
   // the accepting edge, leaving start high so the next beat can follow at once.
   task automatic send_beat(beat_type b);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_action      <= b.act;
      req_row_node    <= b.row;
      req_col_node    <= b.col;
      req_edge_weight <= b.wt;
      req_start_node  <= b.src;
      req_end_node    <= b.dst;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (b.act == ACT_LOAD) begin
         loads++;
         shadow_edge[b.row*32+b.col] = !b.wt[15];
         shadow_wt[b.row*32+b.col]   = b.wt[15] ? 16'd0 : b.wt;
      end else begin
         queries++;
         if (b.typed) route_q.push_back(b.hop);
         else chart_route(b.src, b.dst);
      end
   endtask

   // Stop sending and let every outstanding result drain, then wait out a
   // trailing load that may still be being written.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (route_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_node_count(logic [5:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      active_nodes = clamp_nodes(v);
   endtask

   function automatic beat_type load_beat(int r, int c, int w);
      beat_type b;
      b = '{act: ACT_LOAD, row: 5'(r), col: 5'(c), wt: 16'(w),
            src: 5'($urandom), dst: 5'($urandom), typed: 0, hop: '0};
      return b;
   endfunction

   function automatic beat_type query_beat(int s, int e, bit typed = 0, hop_type h = '0);
      beat_type b;
      b = '{act: ACT_QUERY, row: 5'($urandom), col: 5'($urandom), wt: 16'($urandom),
            src: 5'(s), dst: 5'(e), typed: typed, hop: h};
      return b;
   endfunction

   // Random beat shaped for the current node count: loads favor small
   // positive weights inside the active square so paths get long, with some
   // removed edges and raw 16-bit noise; queries mostly stay in range.
   function automatic beat_type random_beat();
      int n, sel, w;
      n = active_nodes;
      if ($urandom_range(99) < 55) begin
         sel = $urandom_range(99);
         if (sel < 20) w = -1;
         else if (sel < 28) w = $urandom_range(65535);
         else if (sel < 33) w = 32767;
         else w = $urandom_range(1, 12);
         if ($urandom_range(99) < 80)
            return load_beat($urandom_range(n - 1), $urandom_range(n - 1), w);
         return load_beat($urandom_range(31), $urandom_range(31), w);
      end
      if ($urandom_range(99) < 80)
         return query_beat($urandom_range(n - 1), $urandom_range(n - 1));
      return query_beat($urandom_range(31), $urandom_range(31));
   endfunction

   beat_type    directed[$];
   logic [5:0]  phase_counts[6] = '{6'd8, 6'd3, 6'd1, 6'd6, 6'd0, 6'd5};
   int          sent;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // At the reset count of 32 and at a saturated count only queries that
      // never touch the matrix are sent: start equals end is a one-node path.
      send_beat(query_beat(5, 5, 1, '{1'b1, 5'd5, 6'd1, 1'b1}));
      send_beat(query_beat(31, 31, 1, '{1'b1, 5'd31, 6'd1, 1'b1}));
      write_node_count(6'd63);
      send_beat(query_beat(17, 17, 1, '{1'b1, 5'd17, 6'd1, 1'b1}));

      // From here on at most eight nodes are active. Clear that square to
      // "no edge" so that no query ever reads an entry that was never written.
      write_node_count(6'd8);
      for (int i = 0; i < 64; i++) send_beat(load_beat(i / 8, i % 8, -1));

      // Directed part. A removed-edge matrix gives not-found.
      directed.push_back(query_beat(0, 7, 1, '{1'b0, 5'd0, 6'd0, 1'b1}));
      directed.push_back(load_beat(0, 1, 32767));
      directed.push_back(load_beat(1, 7, 0));
      directed.push_back(load_beat(0, 2, -5));          // other negative: no edge
      directed.push_back(load_beat(2, 7, -32768));      // sign bit only: no edge
      directed.push_back(load_beat(0, 6, 100));
      directed.push_back(load_beat(6, 7, 32767));       // longer branch is replaced
      directed.push_back(query_beat(0, 7));
      directed.push_back(query_beat(0, 2, 1, '{1'b0, 5'd0, 6'd0, 1'b1}));
      directed.push_back(load_beat(7, 0, 7));
      directed.push_back(query_beat(7, 6));
      directed.push_back(query_beat(0, 9, 1, '{1'b0, 5'd0, 6'd0, 1'b1}));
      directed.push_back(query_beat(12, 3, 1, '{1'b0, 5'd0, 6'd0, 1'b1}));
      foreach (directed[i]) send_beat(directed[i]);

      // A count of one: only a node paired with itself is found, even one
      // outside the active range.
      write_node_count(6'd1);
      send_beat(query_beat(0, 0, 1, '{1'b1, 5'd0, 6'd1, 1'b1}));
      send_beat(query_beat(17, 17, 1, '{1'b1, 5'd17, 6'd1, 1'b1}));
      send_beat(query_beat(0, 1, 1, '{1'b0, 5'd0, 6'd0, 1'b1}));

      // Random part: six node-count phases of 14 beats each, first with
      // light sender gaps, then heavy gaps, then back to back.
      sent = 0;
      foreach (phase_counts[p]) begin
         write_node_count(phase_counts[p]);
         for (int k = 0; k < 14; k++) begin
            idle_pct = sent < 28 ? 13 : (sent < 56 ? 53 : 0);
            if (sent == 40) drain();
            send_beat(random_beat());
            sent++;
         end
      end

      drain();
      repeat (50) @(posedge clock);
      if (route_q.size() != 0) begin
         errors++;
         $display("%0t %0d expected results never arrived", $time, route_q.size());
      end
      $display("Covered %0d matrix loads and %0d route queries, %0d path beats checked,",
               loads, queries, hops_seen);
      $display("over node counts 32, 63, 8, 1, 3, 6, 0 and 5 with varied sender gaps.");
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
